@@ hw/rtl/sirs_lattice_monte_carlo_step_unit_defines.svh @@
`ifndef SIRS_LATTICE_MONTE_CARLO_STEP_UNIT_DEFINES_SVH
`define SIRS_LATTICE_MONTE_CARLO_STEP_UNIT_DEFINES_SVH

// Assertion macros for the SIRS lattice step unit checker.
// Both expect aclk and aresetn in the scope of use.

// Check cons in the same cycle as ante.
`define SLMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SLMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/slmc_pkg.sv @@
// Shared types and constants of the SIRS lattice step unit.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package slmc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE,
        ST_DONE
    } fsm_state_t;

    typedef enum logic [2:0] {
        SLOT_CENTER,
        SLOT_ROW_DEC,
        SLOT_ROW_INC,
        SLOT_COL_INC,
        SLOT_COL_DEC,
        SLOT_SWAP,
        SLOT_SWAP_DOWN,
        SLOT_SWAP_LEFT
    } rd_slot_t;

    typedef enum logic [1:0] {
        WR_CENTER,
        WR_SWAP,
        WR_SWAP_DOWN,
        WR_SWAP_LEFT
    } wr_slot_t;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] CELL_SUSCEPTIBLE = 2'd0;
    localparam logic [1:0] CELL_INFECTED    = 2'd1;
    localparam logic [1:0] CELL_RECOVERED   = 2'd2;
    localparam logic [1:0] CELL_INVALID     = 2'd3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_LATTICE_SIDE  = 3'd0;
    localparam cfg_index_t CFG_RECOVER_THR   = 3'd1;
    localparam cfg_index_t CFG_IMMUNITY_THR  = 3'd2;
    localparam cfg_index_t CFG_INFECT_THR    = 3'd3;
    localparam cfg_index_t CFG_SWAP_THR      = 3'd4;

    localparam logic [7:0]            SIDE_RESET      = 8'd100;
    localparam logic [CFG_DATA_W-1:0] RECOVER_RESET   = 16'd655;
    localparam logic [CFG_DATA_W-1:0] IMMUNITY_RESET  = 16'd6554;
    localparam logic [CFG_DATA_W-1:0] INFECT_RESET    = 16'd328;
    localparam logic [CFG_DATA_W-1:0] SWAP_RESET      = 16'd328;

    localparam int OUT_TDATA_W = 8;

endpackage

@@ hw/rtl/sirs_lattice_monte_carlo_step_unit.sv @@
// SIRS lattice step unit: lattice in one synchronous RAM, read-modify-write sequencer.
// Depends on slmc_pkg. Update: 8 reads, 1 compute, 4 writes, then a registered result.
// One item at a time: a new one is taken only after the last result is loaded for output;
// the single RAM port pair serializes the eight reads and four writes of an update.
// Reset clears control and configuration to defaults; lattice RAM is not cleared
// and must be loaded by writes before it is read.
`timescale 1ns / 1ps

module sirs_lattice_monte_carlo_step_unit #(
    parameter int MAX_SIDE  = 128,
    parameter int DRAW_BITS = 16,
    localparam int CW       = $clog2(MAX_SIDE),
    localparam int OFF_COL  = CW,
    localparam int OFF_WV   = 2 * CW,
    localparam int OFF_TD   = 2 * CW + 2,
    localparam int OFF_SR   = OFF_TD + DRAW_BITS,
    localparam int OFF_SC   = OFF_SR + CW,
    localparam int OFF_DD   = OFF_SC + CW,
    localparam int OFF_DL   = OFF_DD + DRAW_BITS,
    localparam int IN_W     = OFF_DL + DRAW_BITS,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // site_row, site_col, write_state, transition_draw, swap_row, swap_col,
    // swap_draw_down, swap_draw_left, zero pad
    input  logic [IN_TDATA_W-1:0]             s_tdata,
    // mode
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cell_state, infected_neighbors, zero pad
    output logic [slmc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // range_error
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  slmc_pkg::cfg_index_t              cfg_index,
    input  logic [slmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import slmc_pkg::*;

    localparam int N_W       = ($clog2(MAX_SIDE + 1) > 8) ? $clog2(MAX_SIDE + 1) : 8;
    localparam int ADDR_W    = 2 * CW;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W    = DRAW_BITS + 3;

    typedef logic [CW-1:0]        coord_t;
    typedef logic [N_W-1:0]       side_t;
    typedef logic [DRAW_BITS-1:0] draw_t;

    // configuration
    logic [7:0]            side_reg;
    logic [CFG_DATA_W-1:0] recover_reg;
    logic [CFG_DATA_W-1:0] immunity_reg;
    logic [CFG_DATA_W-1:0] infect_reg;
    logic [CFG_DATA_W-1:0] swap_reg;

    // control
    fsm_state_t state_reg, state_next;
    rd_slot_t   rd_slot_reg, rd_slot_next;
    wr_slot_t   wr_slot_reg, wr_slot_next;
    logic       cap_vld_reg;
    rd_slot_t   cap_slot_reg;
    logic       m_tvalid_reg, m_tvalid_next;

    logic mem_re, mem_we, calc_en, out_load;

    // latched item
    logic [1:0] mode_reg;
    coord_t     row_reg, col_reg, srow_reg, scol_reg;
    logic [1:0] wv_reg;
    draw_t      td_reg, dd_reg, dl_reg;
    logic       err_reg;

    // lattice and read path
    logic [1:0]        lattice_mem [MEM_DEPTH];
    logic [1:0]        rd_data_reg;
    logic [1:0]        cells_reg [7];
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [1:0]        wr_data;
    logic [1:0]        wr_val_reg [4];

    // results
    logic [1:0] res_state_reg, res_state_next;
    logic [2:0] res_nbr_reg, res_nbr_next;
    logic [1:0] out_state_reg;
    logic [2:0] out_nbr_reg;
    logic       out_err_reg;

    // input fields
    coord_t     in_row, in_col, in_srow, in_scol;
    logic [1:0] in_wv;
    logic       in_err;

    assign in_row  = s_tdata[OFF_COL-1:0];
    assign in_col  = s_tdata[OFF_WV-1:OFF_COL];
    assign in_wv   = s_tdata[OFF_TD-1:OFF_WV];
    assign in_srow = s_tdata[OFF_SC-1:OFF_SR];
    assign in_scol = s_tdata[OFF_DD-1:OFF_SC];

    side_t side_ext, n_side;

    assign side_ext = N_W'(side_reg);

    always_comb begin
        priority if (side_ext < N_W'(3)) begin
            n_side = N_W'(3);
        end else if (side_ext > N_W'(MAX_SIDE)) begin
            n_side = N_W'(MAX_SIDE);
        end else begin
            n_side = side_ext;
        end
    end

    assign in_err = (s_tuser != MODE_UPDATE && s_tuser != MODE_WRITE && s_tuser != MODE_READ)
                 || (N_W'(in_row) >= n_side) || (N_W'(in_col) >= n_side)
                 || (s_tuser == MODE_WRITE && in_wv == CELL_INVALID)
                 || (s_tuser == MODE_UPDATE
                     && ((N_W'(in_srow) >= n_side) || (N_W'(in_scol) >= n_side)));

    function automatic coord_t wrap_inc(coord_t v, side_t n);
        side_t t;
        t = N_W'(v) + N_W'(1);
        return (t == n) ? '0 : CW'(t);
    endfunction

    function automatic coord_t wrap_dec(coord_t v, side_t n);
        side_t t;
        t = n - N_W'(1);
        return (v == '0) ? CW'(t) : v - CW'(1);
    endfunction

    coord_t row_inc, row_dec, col_inc, col_dec, srow_inc, scol_dec;

    assign row_inc  = wrap_inc(row_reg, n_side);
    assign row_dec  = wrap_dec(row_reg, n_side);
    assign col_inc  = wrap_inc(col_reg, n_side);
    assign col_dec  = wrap_dec(col_reg, n_side);
    assign srow_inc = wrap_inc(srow_reg, n_side);
    assign scol_dec = wrap_dec(scol_reg, n_side);

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg     <= SIDE_RESET;
            recover_reg  <= RECOVER_RESET;
            immunity_reg <= IMMUNITY_RESET;
            infect_reg   <= INFECT_RESET;
            swap_reg     <= SWAP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LATTICE_SIDE: side_reg     <= cfg_data[7:0];
                CFG_RECOVER_THR:  recover_reg  <= cfg_data;
                CFG_IMMUNITY_THR: immunity_reg <= cfg_data;
                CFG_INFECT_THR:   infect_reg   <= cfg_data;
                CFG_SWAP_THR:     swap_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    rd_slot_t rd_last;
    wr_slot_t wr_last;

    assign rd_last = (mode_reg == MODE_UPDATE) ? SLOT_SWAP_LEFT : SLOT_CENTER;
    assign wr_last = (mode_reg == MODE_UPDATE) ? WR_SWAP_LEFT : WR_CENTER;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_err || s_tuser == MODE_WRITE) begin
                        state_next = ST_CALC;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (rd_slot_reg == rd_last) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!err_reg && (mode_reg == MODE_UPDATE || mode_reg == MODE_WRITE)) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE: begin
                if (wr_slot_reg == wr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        calc_en  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_READ:  mem_re   = 1'b1;
            ST_CALC:  calc_en  = 1'b1;
            ST_WRITE: mem_we   = 1'b1;
            ST_DONE:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign rd_slot_next  = mem_re ? rd_slot_t'(rd_slot_reg + 3'd1) : SLOT_CENTER;
    assign wr_slot_next  = mem_we ? wr_slot_t'(wr_slot_reg + 2'd1) : WR_CENTER;
    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_slot_reg  <= SLOT_CENTER;
            wr_slot_reg  <= WR_CENTER;
            cap_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_slot_reg  <= rd_slot_next;
            wr_slot_reg  <= wr_slot_next;
            cap_vld_reg  <= mem_re;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // latch item on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tuser;
            row_reg  <= in_row;
            col_reg  <= in_col;
            wv_reg   <= in_wv;
            td_reg   <= s_tdata[OFF_SR-1:OFF_TD];
            srow_reg <= in_srow;
            scol_reg <= in_scol;
            dd_reg   <= s_tdata[OFF_DL-1:OFF_DD];
            dl_reg   <= s_tdata[IN_W-1:OFF_DL];
            err_reg  <= in_err;
        end
    end

    // lattice RAM
    always_comb begin
        unique case (rd_slot_reg)
            SLOT_CENTER:    rd_addr = {row_reg, col_reg};
            SLOT_ROW_DEC:   rd_addr = {row_dec, col_reg};
            SLOT_ROW_INC:   rd_addr = {row_inc, col_reg};
            SLOT_COL_INC:   rd_addr = {row_reg, col_inc};
            SLOT_COL_DEC:   rd_addr = {row_reg, col_dec};
            SLOT_SWAP:      rd_addr = {srow_reg, scol_reg};
            SLOT_SWAP_DOWN: rd_addr = {srow_inc, scol_reg};
            SLOT_SWAP_LEFT: rd_addr = {srow_reg, scol_dec};
            default:        rd_addr = {row_reg, col_reg};
        endcase
    end

    always_comb begin
        unique case (wr_slot_reg)
            WR_CENTER:    wr_addr = {row_reg, col_reg};
            WR_SWAP:      wr_addr = {srow_reg, scol_reg};
            WR_SWAP_DOWN: wr_addr = {srow_inc, scol_reg};
            WR_SWAP_LEFT: wr_addr = {srow_reg, scol_dec};
            default:      wr_addr = {row_reg, col_reg};
        endcase
    end

    assign wr_data = wr_val_reg[wr_slot_reg];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lattice_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= lattice_mem[rd_addr];
        end
    end

    // hold read data by slot; the last slot is used straight from the RAM register
    always_ff @(posedge aclk) begin
        cap_slot_reg <= rd_slot_reg;
        if (cap_vld_reg && cap_slot_reg != SLOT_SWAP_LEFT) begin
            cells_reg[cap_slot_reg] <= rd_data_reg;
        end
    end

    // transition and exchange
    draw_t              recover_eff, immunity_eff, infect_eff, swap_eff;
    logic [1:0]         s_old, s_new;
    logic [2:0]         nbr_cnt;
    logic [PROD_W-1:0]  infect_prod;
    logic               hit_swap, hit_down, hit_left, swap_dn, swap_lf;
    logic [1:0]         val_a, val_b, val_c, val_p, fin_down, fin_swap, fin_left;

    assign recover_eff  = DRAW_BITS'(recover_reg);
    assign immunity_eff = DRAW_BITS'(immunity_reg);
    assign infect_eff   = DRAW_BITS'(infect_reg);
    assign swap_eff     = DRAW_BITS'(swap_reg);

    assign s_old   = cells_reg[SLOT_CENTER];
    assign nbr_cnt = {2'b00, cells_reg[SLOT_ROW_DEC] == CELL_INFECTED}
                   + {2'b00, cells_reg[SLOT_ROW_INC] == CELL_INFECTED}
                   + {2'b00, cells_reg[SLOT_COL_INC] == CELL_INFECTED}
                   + {2'b00, cells_reg[SLOT_COL_DEC] == CELL_INFECTED};
    assign infect_prod = PROD_W'(infect_eff) * PROD_W'(nbr_cnt);

    always_comb begin
        s_new = s_old;
        unique case (s_old)
            CELL_INFECTED: begin
                if (td_reg < recover_eff) begin
                    s_new = CELL_RECOVERED;
                end
            end
            CELL_RECOVERED: begin
                if (td_reg < immunity_eff) begin
                    s_new = CELL_SUSCEPTIBLE;
                end
            end
            default: begin
                if (PROD_W'(td_reg) < infect_prod) begin
                    s_new = CELL_INFECTED;
                end
            end
        endcase
    end

    // forward the new center value into exchange partners that alias it
    assign hit_swap = (srow_reg == row_reg) && (scol_reg == col_reg);
    assign hit_down = (srow_inc == row_reg) && (scol_reg == col_reg);
    assign hit_left = (srow_reg == row_reg) && (scol_dec == col_reg);

    assign val_a = hit_swap ? s_new : cells_reg[SLOT_SWAP];
    assign val_b = hit_down ? s_new : cells_reg[SLOT_SWAP_DOWN];
    assign val_c = hit_left ? s_new : rd_data_reg;

    assign swap_dn = dd_reg < swap_eff;
    assign swap_lf = dl_reg < swap_eff;

    assign val_p    = swap_dn ? val_b : val_a;
    assign fin_down = swap_dn ? val_a : val_b;
    assign fin_swap = swap_lf ? val_c : val_p;
    assign fin_left = swap_lf ? val_p : val_c;

    always_comb begin
        res_state_next = CELL_SUSCEPTIBLE;
        res_nbr_next   = 3'd0;
        priority if (err_reg) begin
            res_state_next = CELL_SUSCEPTIBLE;
        end else begin
            unique case (mode_reg)
                MODE_WRITE: res_state_next = wv_reg;
                MODE_READ:  res_state_next = rd_data_reg;
                default: begin
                    res_state_next = s_new;
                    res_nbr_next   = nbr_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (calc_en) begin
            res_state_reg           <= res_state_next;
            res_nbr_reg             <= res_nbr_next;
            wr_val_reg[WR_CENTER]    <= (mode_reg == MODE_WRITE) ? wv_reg : s_new;
            wr_val_reg[WR_SWAP]      <= fin_swap;
            wr_val_reg[WR_SWAP_DOWN] <= fin_down;
            wr_val_reg[WR_SWAP_LEFT] <= fin_left;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_state_reg <= res_state_reg;
            out_nbr_reg   <= res_nbr_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_nbr_reg, out_state_reg});
    assign m_tuser  = out_err_reg;

endmodule

@@ hw/rtl/slmc_checker.sv @@
// Port-level checker for the SIRS lattice step unit, bound to the top level.
// Depends on slmc_pkg and sirs_lattice_monte_carlo_step_unit_defines.svh.
`timescale 1ns / 1ps
`include "sirs_lattice_monte_carlo_step_unit_defines.svh"

module slmc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [slmc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready
);

    import slmc_pkg::*;

    `SLMC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `SLMC_ASSERT_NOW(a_err_clean, m_tvalid && m_tuser, m_tdata == '0, "rejected item carries nonzero result")

    `SLMC_ASSERT_NOW(a_result_range, m_tvalid, m_tdata[1:0] != CELL_INVALID && m_tdata[4:2] <= 3'd4 && m_tdata[7:5] == 3'd0, "result field out of range")

    `SLMC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input beat taken while an item is in flight")

endmodule

bind sirs_lattice_monte_carlo_step_unit slmc_checker u_slmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

@@ tb/sv/tb_sirs_lattice_monte_carlo_step_unit.sv @@
// Self-checking bench for the SIRS lattice step unit: stream in, stream out, config channel.
// Keeps a mirror of the lattice and registers to predict each result beat.
// Depends on slmc_pkg and sirs_lattice_monte_carlo_step_unit.
`timescale 1ns / 1ps

module tb_sirs_lattice_monte_carlo_step_unit;
    import slmc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int DIM = 128;

    typedef struct {
        logic [1:0]  mode;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [1:0]  wval;
        logic [15:0] tdraw;
        logic [6:0]  srow;
        logic [6:0]  scol;
        logic [15:0] ddraw;
        logic [15:0] ldraw;
    } step_item_t;

    typedef struct {
        logic [1:0] state;
        logic [2:0] nbrs;
        logic       err;
    } cell_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic [1:0]  lattice_mirror [0:DIM-1][0:DIM-1];
    logic [7:0]  side_cfg = SIDE_RESET;
    logic [15:0] recover_cfg = RECOVER_RESET;
    logic [15:0] immunity_cfg = IMMUNITY_RESET;
    logic [15:0] infect_cfg = INFECT_RESET;
    logic [15:0] swap_cfg = SWAP_RESET;

    // stimulus bookkeeping
    bit           cell_loaded [0:DIM-1][0:DIM-1];
    step_item_t   pending_steps [$];
    cell_result_t expected_cells [$];
    step_item_t   current_step;
    cell_result_t want_result;
    int           items_queued = 0;
    int           results_seen = 0;
    int           errors = 0;
    int           send_gap = 0;
    int           hold_left = 0;
    int           stuck_cycles = 0;
    bit           no_idle = 1'b0;

    sirs_lattice_monte_carlo_step_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned side_now();
        if (side_cfg < 8'd3) return 3;
        if (side_cfg > 8'd128) return 128;
        return 32'(side_cfg);
    endfunction

    function automatic void exchange_cells(int unsigned r0, int unsigned c0,
                                           int unsigned r1, int unsigned c1);
        logic [1:0] held;
        held = lattice_mirror[r0][c0];
        lattice_mirror[r0][c0] = lattice_mirror[r1][c1];
        lattice_mirror[r1][c1] = held;
    endfunction

    function automatic cell_result_t advance_lattice(step_item_t it);
        cell_result_t res;
        int unsigned  n, up, dn, rt, lf, sd, sl, cnt, thr;
        logic [1:0]   s;
        res.state = CELL_SUSCEPTIBLE;
        res.nbrs = 3'd0;
        res.err = 1'b0;
        n = side_now();
        if (it.mode == MODE_UNUSED || it.row >= n || it.col >= n) begin
            res.err = 1'b1;
        end else if (it.mode == MODE_WRITE) begin
            if (it.wval == CELL_INVALID) begin
                res.err = 1'b1;
            end else begin
                lattice_mirror[it.row][it.col] = it.wval;
                res.state = it.wval;
            end
        end else if (it.mode == MODE_READ) begin
            res.state = lattice_mirror[it.row][it.col];
        end else if (it.srow >= n || it.scol >= n) begin
            res.err = 1'b1;
        end else begin
            up = (it.row + 1 == n) ? 0 : it.row + 1;
            dn = (it.row == 0) ? n - 1 : it.row - 1;
            rt = (it.col + 1 == n) ? 0 : it.col + 1;
            lf = (it.col == 0) ? n - 1 : it.col - 1;
            s = lattice_mirror[it.row][it.col];
            cnt = int'(lattice_mirror[dn][it.col] == CELL_INFECTED)
                + int'(lattice_mirror[up][it.col] == CELL_INFECTED)
                + int'(lattice_mirror[it.row][rt] == CELL_INFECTED)
                + int'(lattice_mirror[it.row][lf] == CELL_INFECTED);
            if (s == CELL_INFECTED) begin
                if (it.tdraw < recover_cfg) s = CELL_RECOVERED;
            end else if (s == CELL_RECOVERED) begin
                if (it.tdraw < immunity_cfg) s = CELL_SUSCEPTIBLE;
            end else begin
                thr = infect_cfg * cnt;
                if (it.tdraw < thr) s = CELL_INFECTED;
            end
            lattice_mirror[it.row][it.col] = s;
            res.state = s;
            res.nbrs = cnt[2:0];
            sd = (it.srow + 1 == n) ? 0 : it.srow + 1;
            sl = (it.scol == 0) ? n - 1 : it.scol - 1;
            if (it.ddraw < swap_cfg) exchange_cells(it.srow, it.scol, sd, it.scol);
            if (it.ldraw < swap_cfg) exchange_cells(it.srow, it.scol, it.srow, sl);
        end
        return res;
    endfunction

    function automatic int idle_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_draw(int unsigned thr);
        int unsigned r, hi, d;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(0, 65535);
        if (r < 70) begin
            hi = thr * 2 + 1;
            return $urandom_range(0, (hi > 65535) ? 65535 : hi);
        end
        d = thr + $urandom_range(0, 2);
        d = (d == 0) ? 0 : d - 1;
        return (d > 65535) ? 65535 : d;
    endfunction

    function automatic step_item_t make_step(logic [1:0] mode, int r, int c, logic [1:0] wv,
                                             int td, int sr, int sc, int dd, int dl);
        step_item_t it;
        it.mode = mode;
        it.row = 7'(r);
        it.col = 7'(c);
        it.wval = wv;
        it.tdraw = 16'(td);
        it.srow = 7'(sr);
        it.scol = 7'(sc);
        it.ddraw = 16'(dd);
        it.ldraw = 16'(dl);
        return it;
    endfunction

    // write a random value into a cell before anything reads it
    function automatic void load_cell(int unsigned r, int unsigned c);
        if (!cell_loaded[r][c]) begin
            pending_steps.push_back(make_step(MODE_WRITE, r, c, 2'($urandom_range(0, 2)),
                $urandom, $urandom, $urandom, $urandom, $urandom));
            cell_loaded[r][c] = 1'b1;
            items_queued++;
        end
    endfunction

    function automatic void enqueue_step(step_item_t it);
        int unsigned n, r, c, sr, sc;
        n = side_now();
        r = 32'(it.row);
        c = 32'(it.col);
        sr = 32'(it.srow);
        sc = 32'(it.scol);
        if (it.mode == MODE_READ && r < n && c < n) load_cell(r, c);
        if (it.mode == MODE_UPDATE && r < n && c < n && sr < n && sc < n) begin
            load_cell(r, c);
            load_cell((r + 1 == n) ? 0 : r + 1, c);
            load_cell((r == 0) ? n - 1 : r - 1, c);
            load_cell(r, (c + 1 == n) ? 0 : c + 1);
            load_cell(r, (c == 0) ? n - 1 : c - 1);
            load_cell(sr, sc);
            load_cell((sr + 1 == n) ? 0 : sr + 1, sc);
            load_cell(sr, (sc == 0) ? n - 1 : sc - 1);
        end
        if (it.mode == MODE_WRITE && it.wval != CELL_INVALID && r < n && c < n)
            cell_loaded[r][c] = 1'b1;
        pending_steps.push_back(it);
        items_queued++;
    endfunction

    function automatic step_item_t random_step();
        step_item_t  it;
        int unsigned n, sel, t;
        n = side_now();
        it = make_step(MODE_UPDATE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
            2'($urandom), 0, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 0, 0);
        case ($urandom_range(0, 2))
            0: t = recover_cfg;
            1: t = immunity_cfg;
            default: t = infect_cfg * $urandom_range(1, 4);
        endcase
        it.tdraw = 16'(pick_draw(t));
        it.ddraw = 16'(pick_draw(swap_cfg));
        it.ldraw = 16'(pick_draw(swap_cfg));
        sel = $urandom_range(0, 99);
        if (sel < 68) begin
            it.mode = MODE_UPDATE;
        end else if (sel < 80) begin
            it.mode = MODE_READ;
        end else if (sel < 92) begin
            it.mode = MODE_WRITE;
            it.wval = 2'($urandom_range(0, 2));
        end else begin
            case ($urandom_range(0, 3))
                0: it.mode = MODE_UNUSED;
                1: begin
                    it.mode = MODE_WRITE;
                    it.wval = CELL_INVALID;
                end
                default: begin
                    it.mode = $urandom_range(0, 1) ? MODE_UPDATE : MODE_READ;
                    if (n < DIM) begin
                        case ($urandom_range(0, 3))
                            0: it.row = 7'($urandom_range(n, DIM - 1));
                            1: it.col = 7'($urandom_range(n, DIM - 1));
                            2: it.srow = 7'($urandom_range(n, DIM - 1));
                            default: it.scol = 7'($urandom_range(n, DIM - 1));
                        endcase
                    end
                end
            endcase
        end
        return it;
    endfunction

    task automatic write_register(cfg_index_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LATTICE_SIDE: side_cfg = val[7:0];
            CFG_RECOVER_THR:  recover_cfg = val;
            CFG_IMMUNITY_THR: immunity_cfg = val;
            CFG_INFECT_THR:   infect_cfg = val;
            CFG_SWAP_THR:     swap_cfg = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic run_phase(logic [7:0] side, logic [15:0] rec, logic [15:0] imm,
                             logic [15:0] inf, logic [15:0] swp, int count, bit calm);
        wait_drained();
        write_register(CFG_LATTICE_SIDE, {8'd0, side});
        write_register(CFG_RECOVER_THR, rec);
        write_register(CFG_IMMUNITY_THR, imm);
        write_register(CFG_INFECT_THR, inf);
        write_register(CFG_SWAP_THR, swp);
        no_idle = calm;
        repeat (count) enqueue_step(random_step());
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_cells.push_back(advance_lattice(current_step));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_steps.size() > 0) begin
                    current_step = pending_steps.pop_front();
                    s_tdata <= {2'b00, current_step.ldraw, current_step.ddraw,
                                current_step.scol, current_step.srow, current_step.tdraw,
                                current_step.wval, current_step.col, current_step.row};
                    s_tuser <= current_step.mode;
                    s_tvalid <= 1'b1;
                    send_gap <= idle_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_cells.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want_result = expected_cells.pop_front();
                    if (m_tdata[1:0] !== want_result.state) begin
                        $error("cell_state: expected %0d, actual %0d",
                               want_result.state, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[4:2] !== want_result.nbrs) begin
                        $error("infected_neighbors: expected %0d, actual %0d",
                               want_result.nbrs, m_tdata[4:2]);
                        errors++;
                    end
                    if (m_tuser !== want_result.err) begin
                        $error("range_error: expected %0d, actual %0d",
                               want_result.err, m_tuser);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30) hold_left <= idle_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats at reset settings, side 100
        enqueue_step(make_step(MODE_WRITE, 0, 0, CELL_INFECTED, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 99, 99, CELL_RECOVERED, 65535, 127, 127,
                               65535, 65535));
        enqueue_step(make_step(MODE_WRITE, 5, 5, CELL_INVALID, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_UNUSED, 1, 1, CELL_SUSCEPTIBLE, 0, 1, 1, 0, 0));
        enqueue_step(make_step(MODE_READ, 127, 0, CELL_SUSCEPTIBLE, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_READ, 0, 127, CELL_SUSCEPTIBLE, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 100, 3, CELL_INFECTED, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_READ, 0, 0, CELL_SUSCEPTIBLE, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_UPDATE, 0, 0, CELL_SUSCEPTIBLE, 0, 99, 99, 0, 0));
        enqueue_step(make_step(MODE_UPDATE, 99, 0, CELL_SUSCEPTIBLE, 65535, 0, 0,
                               65535, 65535));
        enqueue_step(make_step(MODE_UPDATE, 0, 99, CELL_SUSCEPTIBLE, 327, 99, 0, 327, 328));
        enqueue_step(make_step(MODE_UPDATE, 50, 50, CELL_SUSCEPTIBLE, 328, 50, 50, 0, 65535));
        enqueue_step(make_step(MODE_UPDATE, 20, 20, CELL_SUSCEPTIBLE, 0, 100, 20, 0, 0));
        enqueue_step(make_step(MODE_UPDATE, 20, 20, CELL_SUSCEPTIBLE, 0, 20, 127, 0, 0));
        enqueue_step(make_step(MODE_UPDATE, 127, 20, CELL_SUSCEPTIBLE, 0, 20, 20, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 10, 10, CELL_SUSCEPTIBLE, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 9, 10, CELL_INFECTED, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 11, 10, CELL_INFECTED, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 10, 9, CELL_INFECTED, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_WRITE, 10, 11, CELL_INFECTED, 0, 0, 0, 0, 0));
        enqueue_step(make_step(MODE_UPDATE, 10, 10, CELL_SUSCEPTIBLE, 1311, 60, 60,
                               65535, 65535));
        enqueue_step(make_step(MODE_UPDATE, 10, 10, CELL_SUSCEPTIBLE, 654, 60, 60,
                               65535, 65535));
        enqueue_step(make_step(MODE_UPDATE, 10, 10, CELL_SUSCEPTIBLE, 6553, 60, 60,
                               65535, 65535));
        enqueue_step(make_step(MODE_READ, 10, 10, CELL_SUSCEPTIBLE, 0, 0, 0, 0, 0));

        run_phase(8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 80, 1'b0);
        run_phase(8'd128, 16'd0, 16'd0, 16'd0, 16'd0, 16, 1'b0);
        run_phase(8'd0, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 20000)),
                  16'($urandom), 80, 1'b0);
        run_phase(8'd255, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 30000)), 16, 1'b0);
        run_phase(8'd2, 16'($urandom_range(0, 30000)), 16'($urandom),
                  16'($urandom_range(0, 20000)), 16'($urandom), 80, 1'b0);
        run_phase(8'd129, 16'($urandom), 16'($urandom_range(0, 30000)), 16'($urandom),
                  16'($urandom), 16, 1'b0);
        run_phase(8'd5, 16'd30000, 16'd30000, 16'd16384, 16'd32768, 100, 1'b1);
        run_phase(8'd128, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16, 1'b0);
        run_phase(8'd17, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 20000)),
                  16'($urandom), 40, 1'b0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_cells.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/slmc_pkg.sv
hw/rtl/sirs_lattice_monte_carlo_step_unit.sv
hw/rtl/slmc_checker.sv
tb/sv/tb_sirs_lattice_monte_carlo_step_unit.sv
